[rtl/alt_pkg.sv]
// package for the array list table engine
// field widths, operation and status codes, default capacity; no dependencies
package alt_pkg;

  localparam int OP_W  = 3;
  localparam int POS_W = 7;
  localparam int VAL_W = 32;
  localparam int LEN_W = 7;
  localparam int ST_W  = 2;

  localparam int CAPACITY_DEF = 64;

  localparam logic [OP_W-1:0] OP_READ   = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
  localparam logic [OP_W-1:0] OP_SORT   = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

endpackage

[rtl/alt_cmd_if.sv]
// command channel of the array list table engine
// valid/ready plus operation, position and value; uses alt_pkg
interface alt_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [alt_pkg::OP_W-1:0]         operation;
  logic [alt_pkg::POS_W-1:0]        position;
  logic signed [alt_pkg::VAL_W-1:0] value;

  modport source(output valid, output operation, output position, output value,
                 input ready);
  modport sink(input valid, input operation, input position, input value,
               output ready);
endinterface

[rtl/alt_rsp_if.sv]
// response channel of the array list table engine
// valid/ready plus read value, length and status; uses alt_pkg
interface alt_rsp_if;
  logic                             valid;
  logic                             ready;
  logic signed [alt_pkg::VAL_W-1:0] read_value;
  logic [alt_pkg::LEN_W-1:0]        length;
  logic [alt_pkg::ST_W-1:0]         status;

  modport source(output valid, output read_value, output length, output status,
                 input ready);
  modport sink(input valid, input read_value, input length, input status,
               output ready);
endinterface

[rtl/array_list_table_engine.sv]
// channel | dir | payload                              | transfer when
// cmd     | in  | operation, position, value           | cmd.valid && cmd.ready
// rsp     | out | read_value, length, status           | rsp.valid && rsp.ready
//
// one command at a time; n = length before the command, p = position
// read waits on the registered memory; overwrite and rejected commands respond directly
// insert moves p..n up, delete moves p+1..n down (none for append or deleting n)
// one read, one write per move; sort makes one compare a cycle on the single read port
// synchronous reset empties the list; a stalled response holds the next result back
// top level: list memory, shift and sort sequencer; uses alt_pkg, alt_cmd_if, alt_rsp_if
module array_list_table_engine #(
  parameter int CAPACITY = alt_pkg::CAPACITY_DEF
) (
  input logic       clk,
  input logic       rst,
  alt_cmd_if.sink   cmd,
  alt_rsp_if.source rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > alt_pkg::POS_W) ? CW : alt_pkg::POS_W) + 1;
  localparam int DW = CW + 1;
  localparam int VW = alt_pkg::VAL_W;
  localparam int LW = alt_pkg::LEN_W;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_RD_WAIT = 9'b000000010,
    S_SH_RD   = 9'b000000100,
    S_SH_WR   = 9'b000001000,
    S_SH_FIN  = 9'b000010000,
    S_SO_GET  = 9'b000100000,
    S_SO_CMP  = 9'b001000000,
    S_SO_WI   = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_t;

  state_t state, state_next;

  logic [CW-1:0]                count, count_next;
  logic [AW-1:0]                dst, dst_next;
  logic [AW-1:0]                tgt, tgt_next;
  logic                         ins, ins_next;
  logic [AW-1:0]                ii, ii_next;
  logic [AW-1:0]                jj, jj_next;
  logic signed [VW-1:0]         cur, cur_next;
  logic signed [VW-1:0]         val, val_next;
  logic signed [VW-1:0]         res_rd, res_rd_next;
  logic [alt_pkg::ST_W-1:0]     res_st, res_st_next;

  logic signed [VW-1:0] mem [CAPACITY];
  logic signed [VW-1:0] rdata;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [AW-1:0]        mem_raddr;
  logic signed [VW-1:0] mem_wdata;

  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  logic [AW-1:0] pos_m1;
  logic          in_range;
  logic          ins_ok;
  logic          full;
  logic          rsp_free;

  assign pos_x    = XW'(cmd.position);
  assign cnt_x    = XW'(count);
  assign pos_m1   = AW'(pos_x - XW'(1));
  assign in_range = (pos_x != '0) && (pos_x <= cnt_x);
  assign ins_ok   = (pos_x != '0) && (pos_x <= cnt_x + XW'(1));
  assign full     = (cnt_x == XW'(CAPACITY));
  assign rsp_free = !rsp.valid || rsp.ready;

  assign cmd.ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    count_next  = count;
    dst_next    = dst;
    tgt_next    = tgt;
    ins_next    = ins;
    ii_next     = ii;
    jj_next     = jj;
    cur_next    = cur;
    val_next    = val;
    res_rd_next = res_rd;
    res_st_next = res_st;
    mem_we      = 1'b0;
    mem_waddr   = dst;
    mem_wdata   = rdata;
    mem_raddr   = dst;
    unique case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          res_rd_next = '0;
          res_st_next = alt_pkg::ST_OK;
          val_next    = cmd.value;
          tgt_next    = pos_m1;
          ins_next    = (cmd.operation == alt_pkg::OP_INSERT);
          state_next  = S_DONE;
          unique case (cmd.operation)
            alt_pkg::OP_READ: begin
              if (in_range) begin
                mem_raddr  = pos_m1;
                state_next = S_RD_WAIT;
              end else begin
                res_st_next = alt_pkg::ST_RANGE;
              end
            end
            alt_pkg::OP_WRITE: begin
              if (in_range) begin
                mem_we    = 1'b1;
                mem_waddr = pos_m1;
                mem_wdata = cmd.value;
              end else begin
                res_st_next = alt_pkg::ST_RANGE;
              end
            end
            alt_pkg::OP_INSERT: begin
              priority if (full) begin
                res_st_next = alt_pkg::ST_FULL;
              end else if (ins_ok) begin
                if (pos_x == cnt_x + XW'(1)) begin
                  mem_we     = 1'b1;
                  mem_waddr  = pos_m1;
                  mem_wdata  = cmd.value;
                  count_next = count + CW'(1);
                end else begin
                  dst_next   = AW'(count);
                  state_next = S_SH_RD;
                end
              end else begin
                res_st_next = alt_pkg::ST_RANGE;
              end
            end
            alt_pkg::OP_DELETE: begin
              if (in_range) begin
                if (pos_x == cnt_x) begin
                  count_next = count - CW'(1);
                end else begin
                  dst_next   = pos_m1;
                  state_next = S_SH_RD;
                end
              end else begin
                res_st_next = alt_pkg::ST_RANGE;
              end
            end
            alt_pkg::OP_SORT: begin
              if (cnt_x >= XW'(2)) begin
                mem_raddr  = '0;
                ii_next    = '0;
                jj_next    = AW'(1);
                state_next = S_SO_GET;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RD_WAIT: begin
        res_rd_next = rdata;
        state_next  = S_DONE;
      end
      S_SH_RD: begin
        mem_raddr  = ins ? (dst - AW'(1)) : (dst + AW'(1));
        state_next = S_SH_WR;
      end
      S_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = dst;
        mem_wdata = rdata;
        if (ins) begin
          dst_next   = dst - AW'(1);
          state_next = ((dst - AW'(1)) == tgt) ? S_SH_FIN : S_SH_RD;
        end else begin
          dst_next = dst + AW'(1);
          if (DW'(dst) + DW'(2) == DW'(count)) begin
            count_next = count - CW'(1);
            state_next = S_DONE;
          end else begin
            state_next = S_SH_RD;
          end
        end
      end
      S_SH_FIN: begin
        mem_we     = 1'b1;
        mem_waddr  = tgt;
        mem_wdata  = val;
        count_next = count + CW'(1);
        state_next = S_DONE;
      end
      S_SO_GET: begin
        cur_next   = rdata;
        mem_raddr  = jj;
        state_next = S_SO_CMP;
      end
      S_SO_CMP: begin
        mem_raddr = jj + AW'(1);
        if (cur > rdata) begin
          mem_we    = 1'b1;
          mem_waddr = jj;
          mem_wdata = cur;
          cur_next  = rdata;
        end
        if (DW'(jj) + DW'(1) == DW'(count)) begin
          state_next = S_SO_WI;
        end else begin
          jj_next = jj + AW'(1);
        end
      end
      S_SO_WI: begin
        mem_we    = 1'b1;
        mem_waddr = ii;
        mem_wdata = cur;
        if (DW'(ii) + DW'(2) == DW'(count)) begin
          state_next = S_DONE;
        end else begin
          mem_raddr  = ii + AW'(1);
          ii_next    = ii + AW'(1);
          jj_next    = ii + AW'(2);
          state_next = S_SO_GET;
        end
      end
      S_DONE: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // list memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    dst    <= dst_next;
    tgt    <= tgt_next;
    ins    <= ins_next;
    ii     <= ii_next;
    jj     <= jj_next;
    cur    <= cur_next;
    val    <= val_next;
    res_rd <= res_rd_next;
    res_st <= res_st_next;
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if ((state == S_DONE) && rsp_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && rsp_free) begin
      rsp.read_value <= res_rd;
      rsp.length     <= LW'(count);
      rsp.status     <= res_st;
    end
  end

endmodule

[rtl/alt_checker.sv]
// port-level checks for the array list table engine, bound to the top level
// uses alt_pkg; watches the cmd and rsp channels
module alt_checker #(
  parameter int CAPACITY = alt_pkg::CAPACITY_DEF
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             cmd_valid,
  input logic                             cmd_ready,
  input logic                             rsp_valid,
  input logic                             rsp_ready,
  input logic signed [alt_pkg::VAL_W-1:0] read_value,
  input logic [alt_pkg::LEN_W-1:0]        length,
  input logic [alt_pkg::ST_W-1:0]         status
);

  localparam int LW = alt_pkg::LEN_W;
  localparam logic [LW-1:0] FULL_LEN = LW'(CAPACITY);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_value) && $stable(length)
      && $stable(status))
    else $error("response changed while stalled");

  a_full_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == alt_pkg::ST_FULL) |-> length == FULL_LEN)
    else $error("full status with list not at capacity");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != alt_pkg::ST_OK) |-> read_value == '0)
    else $error("nonzero read value on rejected command");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command taken while busy");

  a_rst_quiet: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("response valid right after reset");

endmodule

bind array_list_table_engine alt_checker #(.CAPACITY(CAPACITY)) u_alt_checker (
  .clk        (clk),
  .rst        (rst),
  .cmd_valid  (cmd.valid),
  .cmd_ready  (cmd.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .read_value (rsp.read_value),
  .length     (rsp.length),
  .status     (rsp.status)
);
